@@ rtl/sfg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled font glyph row generator package
// Word types, font constants and the 5x7 font lookup shared by the block.
// ----------------------------------------------------------------------------
package sfg_pkg;

	localparam int GlyphW     = 5;
	localparam int GlyphH     = 7;
	localparam int TextLeft   = 8;
	localparam int TextTop    = 7;
	localparam int MaxRows    = 14;
	localparam int MaskW      = 10;
	localparam int CoordW     = 13;
	localparam int QueueDepth = 4;

	localparam logic [7:0] HeadRed   = 8'd255;
	localparam logic [7:0] HeadGreen = 8'd240;
	localparam logic [7:0] HeadBlue  = 8'd110;
	localparam logic [7:0] TextGrey  = 8'd235;

	typedef logic [0:GlyphH-1][GlyphW-1:0] glyph_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [5:0] char_pos;
		logic [2:0] text_line;
		logic       heading;
	} char_word_t;

	typedef struct packed {
		logic [7:0] pixel_y;
		logic [8:0] pixel_x;
		logic [9:0] row_mask;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_row;
	} row_word_t;

	typedef struct packed {
		glyph_t     glyph;
		logic [7:0] ybase;
		logic [8:0] xbase;
		logic [9:0] col_ok;
		logic [3:0] nrows;
		logic       heading;
	} job_t;

	function automatic glyph_t font_lookup(input logic [7:0] code);
		glyph_t g;
		unique case (code)
			"A": g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
			"B": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
			"C": g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
			"D": g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
			"E": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
			"F": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
			"G": g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
			"H": g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
			"I": g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31};
			"J": g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
			"K": g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
			"L": g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
			"M": g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
			"N": g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
			"O": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
			"P": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
			"Q": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
			"R": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
			"S": g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
			"T": g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
			"U": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
			"V": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
			"W": g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
			"X": g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
			"Y": g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
			"Z": g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
			"0": g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
			"1": g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
			"2": g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
			"3": g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
			"4": g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
			"5": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
			"6": g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
			"7": g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
			"8": g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
			"9": g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
			":": g = {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
			".": g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd6};
			"-": g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
			"_": g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
			"/": g = {5'd1, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd16};
			"|": g = {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
			"(": g = {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
			")": g = {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
			"[": g = {5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14};
			"]": g = {5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14};
			"+": g = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
			"=": g = {5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0};
			"%": g = {5'd17, 5'd2, 5'd4, 5'd8, 5'd17, 5'd0, 5'd0};
			" ": g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
			default: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

@@ rtl/scaled_font_glyph_row_generator_core.sv @@
`default_nettype none
// A kept character is written into the job queue, and its rows are then registered in the result register.
// Throughput: one row word per cycle while the result register is empty or being popped,
// set by the back-end row sequencer; a dropped character is never queued.
// A four-entry job queue lets the front keep accepting while rows are drawn.
// Reset: asynchronous, active low; queue and result register come up empty.
// ----------------------------------------------------------------------------
// Scaled font glyph row generator
// On-screen display character generator producing doubled 5x7 glyph rows.
// ----------------------------------------------------------------------------
module scaled_font_glyph_row_generator_core #(
	parameter int CANVAS_WIDTH  = 512,
	parameter int CANVAS_HEIGHT = 138,
	parameter int GLYPH_SCALE   = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  sfg_pkg::char_word_t  char_word,
	output logic                 empty,
	input  wire                  pop,
	output sfg_pkg::row_word_t   row_word
);
	import sfg_pkg::*;

	job_t  front_job;
	job_t  head_job;
	logic  keep;
	logic  q_push;
	logic  q_pop;
	logic  q_empty;
	logic  mid_item;
	logic  row_valid;

	assign q_push = push && !full && keep;
	assign empty  = !row_valid;

	sfg_front #(
		.CANVAS_WIDTH (CANVAS_WIDTH),
		.CANVAS_HEIGHT(CANVAS_HEIGHT),
		.GLYPH_SCALE  (GLYPH_SCALE)
	) u_front (
		.char_word(char_word),
		.job      (front_job),
		.keep     (keep)
	);

	sfg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(front_job),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(head_job),
		.empty  (q_empty)
	);

	sfg_back #(
		.GLYPH_SCALE(GLYPH_SCALE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.job_valid(!q_empty),
		.job_done (q_pop),
		.mid_item (mid_item),
		.row_word (row_word),
		.row_valid(row_valid),
		.row_pop  (pop)
	);

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("Queued character was lost.");

	a_mid_item_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		mid_item |-> !q_empty)
		else $error("Row sequencer is mid character with no queued job.");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_push) |=> !full)
		else $error("Queue still full after a job retired.");

endmodule
`default_nettype wire

@@ rtl/sfg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph row generator front end
// Classifies an incoming character word: range checks, font lookup, origin
// and the number of rows that fit on the canvas.
// ----------------------------------------------------------------------------
module sfg_front #(
	parameter int CANVAS_WIDTH  = 512,
	parameter int CANVAS_HEIGHT = 138,
	parameter int GLYPH_SCALE   = 2
) (
	input  sfg_pkg::char_word_t char_word,
	output sfg_pkg::job_t       job,
	output logic                keep
);
	import sfg_pkg::*;

	localparam int Advance  = (GlyphW + 1) * GLYPH_SCALE;
	localparam int MaxChars = (CANVAS_WIDTH - 2 * TextLeft) / Advance;
	localparam int LinePitch = (GlyphH + 2) * GLYPH_SCALE;
	localparam int Rows     = (GlyphH * GLYPH_SCALE > MaxRows) ? MaxRows : GlyphH * GLYPH_SCALE;
	localparam int Total    = GlyphW * GLYPH_SCALE;

	logic [CoordW-1:0] xbase;
	logic [CoordW-1:0] ybase;
	logic [CoordW-1:0] room;
	logic              in_range;
	logic              fits;

	assign xbase = CoordW'(TextLeft) + CoordW'(char_word.char_pos) * CoordW'(Advance);
	assign ybase = CoordW'(TextTop) + CoordW'(char_word.text_line) * CoordW'(LinePitch);
	assign room  = CoordW'(CANVAS_HEIGHT) - ybase;

	assign in_range = CoordW'(char_word.char_pos) < CoordW'(MaxChars);
	assign fits     = ybase < CoordW'(CANVAS_HEIGHT);
	assign keep     = in_range && fits;

	always_comb begin
		job.glyph   = font_lookup(char_word.char_code);
		job.ybase   = ybase[7:0];
		job.xbase   = xbase[8:0];
		job.heading = char_word.heading;
		if (room >= CoordW'(Rows)) begin
			job.nrows = 4'(Rows);
		end else begin
			job.nrows = room[3:0];
		end
		for (int p = 0; p < MaskW; p++) begin
			if (p < Total) begin
				job.col_ok[p] = (xbase + CoordW'(Total - 1 - p)) < CoordW'(CANVAS_WIDTH);
			end else begin
				job.col_ok[p] = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/sfg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph job queue
// Small FIFO of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module sfg_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  sfg_pkg::job_t       wr_data,
	output logic                full,
	input  wire                 rd_en,
	output sfg_pkg::job_t       rd_data,
	output logic                empty
);
	import sfg_pkg::*;

	localparam int AW = $clog2(QueueDepth);

	job_t          mem [QueueDepth];
	logic [AW:0]   wr_ptr_q;
	logic [AW:0]   rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_data = mem[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sfg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph row generator back end
// Walks the scaled rows of the character at the queue head into a result
// register, one row per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module sfg_back #(
	parameter int GLYPH_SCALE = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sfg_pkg::job_t        job,
	input  wire                  job_valid,
	output logic                 job_done,
	output logic                 mid_item,
	output sfg_pkg::row_word_t   row_word,
	output logic                 row_valid,
	input  wire                  row_pop
);
	import sfg_pkg::*;

	localparam int Total = GlyphW * GLYPH_SCALE;
	localparam int RepW  = (GLYPH_SCALE > 1) ? $clog2(GLYPH_SCALE) : 1;

	logic [3:0]      row_q;
	logic [2:0]      grow_q;
	logic [RepW-1:0] rep_q;
	logic            out_valid_q;
	row_word_t       out_q;

	logic            adv;
	logic            last;
	logic [4:0]      bits;
	logic [9:0]      mask;

	assign adv       = job_valid && (!out_valid_q || row_pop);
	assign last      = (row_q == job.nrows - 4'd1);
	assign job_done  = adv && last;
	assign mid_item  = (row_q != 4'd0);
	assign bits      = job.glyph[grow_q];
	assign row_word  = out_q;
	assign row_valid = out_valid_q;

	always_comb begin
		for (int p = 0; p < MaskW; p++) begin
			if (p < Total) begin
				mask[p] = bits[GlyphW - 1 - (Total - 1 - p) / GLYPH_SCALE] & job.col_ok[p];
			end else begin
				mask[p] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			grow_q      <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (last) begin
					row_q  <= '0;
					grow_q <= '0;
					rep_q  <= '0;
				end else begin
					row_q <= row_q + 4'd1;
					if (rep_q == RepW'(GLYPH_SCALE - 1)) begin
						rep_q  <= '0;
						grow_q <= grow_q + 3'd1;
					end else begin
						rep_q <= rep_q + 1'b1;
					end
				end
			end else if (row_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.pixel_y  <= job.ybase + 8'(row_q);
			out_q.pixel_x  <= job.xbase;
			out_q.row_mask <= mask;
			out_q.red      <= job.heading ? HeadRed : TextGrey;
			out_q.green    <= job.heading ? HeadGreen : TextGrey;
			out_q.blue     <= job.heading ? HeadBlue : TextGrey;
			out_q.last_row <= last;
		end
	end

endmodule
`default_nettype wire
